@@ rtl/stdt_pkg.sv @@
`timescale 1ns / 1ps

package stdt_pkg;

    localparam int CODE_BITS     = 6;
    localparam int CHAR_BITS     = 7;
    localparam int OUT_COL_BITS  = 8;
    localparam int STOP_BITS     = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 8;
    localparam int STOP_SLOTS    = 4;
    localparam int RESULT_LIMIT  = 64;
    localparam int COUNT_BITS    = 7;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXPAND_TABS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_FIRST  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_SECOND = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_THIRD  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_FOURTH = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAB_REPEAT  = 3'd5;

    // register reset values
    localparam logic                 RST_EXPAND_TABS = 1'b1;
    localparam logic [STOP_BITS-1:0] RST_STOP_FIRST  = 8'd8;
    localparam logic [STOP_BITS-1:0] RST_STOP_SECOND = 8'd21;
    localparam logic [STOP_BITS-1:0] RST_STOP_THIRD  = 8'd31;
    localparam logic [STOP_BITS-1:0] RST_STOP_FOURTH = 8'd39;
    localparam logic [STOP_BITS-1:0] RST_TAB_REPEAT  = 8'd8;

    localparam logic [CHAR_BITS-1:0] ASCII_TAB     = 7'h09;
    localparam logic [CHAR_BITS-1:0] ASCII_NEWLINE = 7'h0A;
    localparam logic [CHAR_BITS-1:0] ASCII_SPACE   = 7'h20;

    localparam logic [CHAR_BITS-1:0] CODE_TO_ASCII [2**CODE_BITS] = '{
        7'h5B, 7'h25, 7'h5D, 7'h21, 7'h26, 7'h2A, 7'h3A, 7'h5F,
        7'h2B, 7'h09, 7'h3F, 7'h22, 7'h27, 7'h0A, 7'h28, 7'h29,
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h3B, 7'h3D, 7'h2C, 7'h2D, 7'h2E, 7'h2F,
        7'h20, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
        7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F,
        7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
        7'h58, 7'h59, 7'h5A, 7'h24, 7'h23, 7'h40, 7'h5E, 7'h62
    };

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
        logic pend_valid;
    } t_status;

endpackage

@@ rtl/stdt_if.sv @@
`timescale 1ns / 1ps

interface stdt_in_if #(
    parameter int WORD_BITS = 30
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] packed_word;
    logic                 restart;

    modport source (output valid, output packed_word, output restart, input ready);
    modport sink   (input valid, input packed_word, input restart, output ready);
endinterface

interface stdt_out_if;
    logic                                valid;
    logic                                ready;
    logic [stdt_pkg::CHAR_BITS-1:0]      character;
    logic [stdt_pkg::OUT_COL_BITS-1:0]   column_after;
    logic                                last;

    modport source (output valid, output character, output column_after, output last,
                    input ready);
    modport sink   (input valid, input character, input column_after, input last,
                    output ready);
endinterface

@@ rtl/stdt_ctrl.sv @@
`timescale 1ns / 1ps

module stdt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  stdt_pkg::t_status i_status,
    output logic              o_in_ready,
    output stdt_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (r_in_ready && i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.done) begin
                    n_state = S_FINISH;
                end else if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FINISH: begin
                // last flag goes onto the held result on its way out
                if (!i_status.pend_valid || i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

@@ rtl/stdt_datapath.sv @@
`timescale 1ns / 1ps

module stdt_datapath #(
    parameter int CHARS_PER_WORD = 5,
    parameter int STOP_COUNT     = 4,
    parameter int COLUMN_BITS    = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  stdt_pkg::t_cmd                           i_cmd,
    input  logic [CHARS_PER_WORD*stdt_pkg::CODE_BITS-1:0] i_packed_word,
    input  logic                                     i_restart,
    input  logic                                     i_cfg_we,
    input  logic [stdt_pkg::CFG_IDX_BITS-1:0]        i_cfg_idx,
    input  logic [stdt_pkg::CFG_DATA_BITS-1:0]       i_cfg_data,
    input  logic                                     i_out_ready,
    output stdt_pkg::t_status                        o_status,
    output logic                                     o_out_valid,
    output logic [stdt_pkg::CHAR_BITS-1:0]           o_character,
    output logic [stdt_pkg::OUT_COL_BITS-1:0]        o_column_after,
    output logic                                     o_last
);

    localparam int WB = CHARS_PER_WORD * stdt_pkg::CODE_BITS;
    localparam int CB = COLUMN_BITS;
    localparam int SW = ((CB > stdt_pkg::STOP_BITS) ? CB : stdt_pkg::STOP_BITS) + 1;
    localparam int IW = (CHARS_PER_WORD > 1) ? $clog2(CHARS_PER_WORD) : 1;
    localparam logic [CB-1:0] COL_MAX = '1;
    localparam logic [CB-1:0] COL_ONE = CB'(1);

    function automatic logic [CB-1:0] clamp_col(input logic [SW-1:0] v);
        if (v > SW'(COL_MAX)) begin
            return COL_MAX;
        end
        return v[CB-1:0];
    endfunction

    // configuration
    logic                              r_expand;
    logic [stdt_pkg::STOP_BITS-1:0]    r_stop [stdt_pkg::STOP_SLOTS];
    logic [stdt_pkg::STOP_BITS-1:0]    r_repeat;

    // line state
    logic [CB-1:0] r_column, n_column;
    logic [1:0]    r_stop_idx, n_stop_idx;
    logic [CB-1:0] r_next_stop, n_next_stop;
    logic          r_line_start, n_line_start;

    // word walk
    logic [WB-1:0]                      r_word, n_word;
    logic [IW-1:0]                      r_idx, n_idx;
    logic                               r_done, n_done;
    logic                               r_newline, n_newline;
    logic [stdt_pkg::COUNT_BITS-1:0]    r_count, n_count;

    // held result and output register
    logic                               r_p_valid, n_p_valid;
    logic [stdt_pkg::CHAR_BITS-1:0]     r_p_char, n_p_char;
    logic [CB-1:0]                      r_p_col, n_p_col;
    logic                               r_o_valid, n_o_valid;
    logic [stdt_pkg::CHAR_BITS-1:0]     r_o_char, n_o_char;
    logic [CB-1:0]                      r_o_col, n_o_col;
    logic                               r_o_last, n_o_last;

    logic                               out_free;
    logic [stdt_pkg::CHAR_BITS-1:0]     cur_char;
    logic                               emit;
    logic [stdt_pkg::CHAR_BITS-1:0]     emit_char;
    logic                               advance;
    logic [CB-1:0]                      col_inc;

    assign out_free = !r_o_valid || i_out_ready;
    assign cur_char = stdt_pkg::CODE_TO_ASCII[r_word[WB-1 -: stdt_pkg::CODE_BITS]];
    assign col_inc  = (r_column < COL_MAX) ? (r_column + COL_ONE) : r_column;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expand  <= stdt_pkg::RST_EXPAND_TABS;
            r_stop[0] <= stdt_pkg::RST_STOP_FIRST;
            r_stop[1] <= stdt_pkg::RST_STOP_SECOND;
            r_stop[2] <= stdt_pkg::RST_STOP_THIRD;
            r_stop[3] <= stdt_pkg::RST_STOP_FOURTH;
            r_repeat  <= stdt_pkg::RST_TAB_REPEAT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stdt_pkg::CFG_EXPAND_TABS: r_expand  <= i_cfg_data[0];
                stdt_pkg::CFG_STOP_FIRST:  r_stop[0] <= i_cfg_data;
                stdt_pkg::CFG_STOP_SECOND: r_stop[1] <= i_cfg_data;
                stdt_pkg::CFG_STOP_THIRD:  r_stop[2] <= i_cfg_data;
                stdt_pkg::CFG_STOP_FOURTH: r_stop[3] <= i_cfg_data;
                stdt_pkg::CFG_TAB_REPEAT:  r_repeat  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_column     = r_column;
        n_stop_idx   = r_stop_idx;
        n_next_stop  = r_next_stop;
        n_line_start = r_line_start;
        n_word       = r_word;
        n_idx        = r_idx;
        n_done       = r_done;
        n_newline    = r_newline;
        n_count      = r_count;
        n_p_valid    = r_p_valid;
        n_p_char     = r_p_char;
        n_p_col      = r_p_col;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_char     = r_o_char;
        n_o_col      = r_o_col;
        n_o_last     = r_o_last;
        emit         = 1'b0;
        emit_char    = cur_char;
        advance      = 1'b0;

        if (i_cmd.load) begin
            n_word    = i_packed_word;
            n_idx     = '0;
            n_done    = 1'b0;
            n_newline = 1'b0;
            n_count   = '0;
            if (i_restart || r_line_start || r_column <= COL_ONE) begin
                n_column    = COL_ONE;
                n_stop_idx  = '0;
                n_next_stop = clamp_col(SW'(r_stop[0]));
            end
        end

        if (i_cmd.step) begin
            if (cur_char == stdt_pkg::ASCII_TAB && r_expand) begin
                if (r_column < r_next_stop) begin
                    emit      = 1'b1;
                    emit_char = stdt_pkg::ASCII_SPACE;
                end else begin
                    advance = 1'b1;
                    if ({1'b0, r_stop_idx} + 3'd1 < 3'(STOP_COUNT)) begin
                        n_stop_idx  = r_stop_idx + 2'd1;
                        n_next_stop = clamp_col(SW'(r_stop[n_stop_idx]));
                    end else begin
                        n_next_stop = clamp_col(SW'(r_next_stop) + SW'(r_repeat));
                    end
                end
            end else begin
                emit = 1'b1;
                if (cur_char == stdt_pkg::ASCII_NEWLINE) begin
                    n_done    = 1'b1;
                    n_newline = 1'b1;
                end else begin
                    advance = 1'b1;
                end
            end

            if (emit) begin
                n_column = col_inc;
                // results past the limit are dropped, column still moves
                if (r_count < stdt_pkg::COUNT_BITS'(stdt_pkg::RESULT_LIMIT)) begin
                    n_count = r_count + 1'b1;
                    if (r_p_valid) begin
                        n_o_valid = 1'b1;
                        n_o_char  = r_p_char;
                        n_o_col   = r_p_col;
                        n_o_last  = 1'b0;
                    end
                    n_p_valid = 1'b1;
                    n_p_char  = emit_char;
                    n_p_col   = col_inc;
                end
            end

            if (advance) begin
                n_word = r_word << stdt_pkg::CODE_BITS;
                n_idx  = r_idx + 1'b1;
                if (r_idx == IW'(CHARS_PER_WORD - 1)) begin
                    n_done = 1'b1;
                end
            end
        end

        if (i_cmd.finish) begin
            if (r_p_valid) begin
                n_o_valid = 1'b1;
                n_o_char  = r_p_char;
                n_o_col   = r_p_col;
                n_o_last  = 1'b1;
                n_p_valid = 1'b0;
            end
            if (r_newline) begin
                n_column     = COL_ONE;
                n_stop_idx   = '0;
                n_next_stop  = clamp_col(SW'(r_stop[0]));
                n_line_start = 1'b1;
            end else begin
                n_line_start = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= COL_ONE;
            r_stop_idx   <= '0;
            r_next_stop  <= clamp_col(SW'(stdt_pkg::RST_STOP_FIRST));
            r_line_start <= 1'b1;
            r_done       <= 1'b0;
            r_newline    <= 1'b0;
            r_count      <= '0;
            r_p_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_column     <= n_column;
            r_stop_idx   <= n_stop_idx;
            r_next_stop  <= n_next_stop;
            r_line_start <= n_line_start;
            r_done       <= n_done;
            r_newline    <= n_newline;
            r_count      <= n_count;
            r_p_valid    <= n_p_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_idx    <= n_idx;
        r_p_char <= n_p_char;
        r_p_col  <= n_p_col;
        r_o_char <= n_o_char;
        r_o_col  <= n_o_col;
        r_o_last <= n_o_last;
    end

    assign o_status.done       = r_done;
    assign o_status.out_free   = out_free;
    assign o_status.pend_valid = r_p_valid;

    assign o_out_valid    = r_o_valid;
    assign o_character    = r_o_char;
    assign o_column_after = stdt_pkg::OUT_COL_BITS'(r_o_col);
    assign o_last         = r_o_last;

    a_column_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column != '0)
        else $error("column fell to zero");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stdt_pkg::COUNT_BITS'(stdt_pkg::RESULT_LIMIT))
        else $error("result count past limit");

    a_finish_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_p_valid |=> r_o_valid && r_o_last && !r_p_valid)
        else $error("held result not released with last flag");

endmodule

@@ rtl/sixbit_text_decoder_tabs_top.sv @@
`timescale 1ns / 1ps

// Six-bit text decoder with tab expansion.
// i_in  : one request per packed word (CHARS_PER_WORD codes, first code in the
//         top bits) plus a restart flag that forces a line start.
// o_out : one request per ASCII character, with the column after it and a last
//         flag on the final character of the word.
// i_cfg_*: register writes (expand_tabs, four tab stops, tab_repeat), which the user
//         must make only while the block is idle; the block does not enforce this.
// Sequence: a word is loaded, then stepped once per emitted character and
//         once per tab that reaches its stop, each step waiting while o_out
//         is not free; the word is then seen to be done and finished. Padding
//         dropped past the result limit is still stepped space by space.
//         Each result is held back one step to learn whether it is last.
// i_in.ready is high only between words.
// Reset: synchronous, active low; column 1, first stop, line start pending,
//         registers back to their defaults, no results in flight.
// Stall: while o_out is not taken the sequencer holds; nothing is lost.
module sixbit_text_decoder_tabs_top #(
    parameter int CHARS_PER_WORD = 5,
    parameter int STOP_COUNT     = 4,
    parameter int COLUMN_BITS    = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    stdt_in_if.sink                              i_in,
    stdt_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [stdt_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [stdt_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    stdt_pkg::t_cmd    cmd;
    stdt_pkg::t_status status;
    logic              in_ready;

    stdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    stdt_datapath #(
        .CHARS_PER_WORD (CHARS_PER_WORD),
        .STOP_COUNT     (STOP_COUNT),
        .COLUMN_BITS    (COLUMN_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_packed_word  (i_in.packed_word),
        .i_restart      (i_in.restart),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (o_out.ready),
        .o_status       (status),
        .o_out_valid    (o_out.valid),
        .o_character    (o_out.character),
        .o_column_after (o_out.column_after),
        .o_last         (o_out.last)
    );

    assign i_in.ready = in_ready;

    // between words nothing may still be held back
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !status.pend_valid)
        else $error("held result while idle");

    // one word at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && in_ready |=> !in_ready)
        else $error("second word taken while busy");

    // a waiting result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.character)
            && $stable(o_out.column_after) && $stable(o_out.last))
        else $error("result changed while stalled");

endmodule

@@ sim/tb_sixbit_text_decoder_tabs_top.sv @@
`timescale 1ns / 1ps

// Checks the six-bit text decoder against a behavioral model of its decoding:
// every accepted word is decoded here into the characters it should produce,
// and each character request leaving the block is compared with the oldest
// one waiting.
module tb_sixbit_text_decoder_tabs_top;

    localparam int CHARS     = 5;
    localparam int STOPS     = 4;
    localparam int COL_BITS  = 8;
    localparam int COL_TOP   = 2**COL_BITS - 1;
    localparam int WORD_W    = CHARS * stdt_pkg::CODE_BITS;
    localparam int LONG_HOLD = 300;    // receiver hold-off, in cycles
    localparam int SETTLE    = 16;     // quiet cycles before a register write
    localparam int SEG_WORDS = 25;     // random words per idling mode

    // six-bit code -> ASCII, indexed by code
    localparam string CODE_GLYPHS =
        "[%]!&*:_+\t?\"'\n()0123456789;=,-./ ABCDEFGHIJKLMNOPQRSTUVWXYZ$#@^b";

    localparam logic [stdt_pkg::CODE_BITS-1:0] CODE_TAB     = 6'd9;
    localparam logic [stdt_pkg::CODE_BITS-1:0] CODE_NEWLINE = 6'd13;
    localparam logic [stdt_pkg::CODE_BITS-1:0] CODE_BLANK   = 6'd32;
    localparam logic [stdt_pkg::CODE_BITS-1:0] CODE_A       = 6'd33;

    typedef struct packed {
        logic [stdt_pkg::CHAR_BITS-1:0]    character;
        logic [stdt_pkg::OUT_COL_BITS-1:0] column_after;
        logic                              last;
    } t_decoded_char;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [stdt_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [stdt_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    stdt_in_if #(.WORD_BITS(WORD_W)) in_if ();
    stdt_out_if                      out_if ();

    sixbit_text_decoder_tabs_top #(
        .CHARS_PER_WORD (CHARS),
        .STOP_COUNT     (STOPS),
        .COLUMN_BITS    (COL_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the block's registers and line state
    bit expand_on;
    int stop_col [STOPS];
    int stop_step;
    int cur_col;
    int stop_idx;
    int next_stop;
    bit at_line_start;

    t_decoded_char expected_chars [$];
    int            error_count   = 0;
    int            send_idle_pct = 20;
    int            recv_idle_pct = 82;
    int            hold_asks     = 0;  // bumped by a test to request a long hold-off
    int            hold_seen     = 0;
    int            hold_left     = 0;

    // ---------------------------------------------------------------
    // Decoding model
    // ---------------------------------------------------------------
    function automatic int clamp_col(input int v);
        return (v > COL_TOP) ? COL_TOP : v;
    endfunction

    function automatic void begin_line();
        cur_col   = 1;
        stop_idx  = 0;
        next_stop = clamp_col(stop_col[0]);
    endfunction

    // Column advances up to its top value; only the first RESULT_LIMIT characters of a
    // word are returned. Each one is held back until the next is known so
    // the final one can carry last.
    function automatic void put_char(input logic [stdt_pkg::CHAR_BITS-1:0] ch,
                                     inout t_decoded_char held, inout bit have_held,
                                     inout int produced);
        if (cur_col < COL_TOP) cur_col++;
        if (produced < stdt_pkg::RESULT_LIMIT) begin
            if (have_held) expected_chars.push_back(held);
            held.character    = ch;
            held.column_after = cur_col[stdt_pkg::OUT_COL_BITS-1:0];
            held.last         = 1'b0;
            have_held         = 1'b1;
            produced++;
        end
    endfunction

    function automatic void decode_word(input logic [WORD_W-1:0] word, input logic restart);
        t_decoded_char                  held;
        bit                             have_held;
        bit                             saw_newline;
        int                             produced;
        int                             k;
        logic [stdt_pkg::CODE_BITS-1:0] code;
        byte                            glyph;
        logic [stdt_pkg::CHAR_BITS-1:0] ch;
        held        = '0;
        have_held   = 1'b0;
        saw_newline = 1'b0;
        produced    = 0;
        if (restart || at_line_start || cur_col <= 1) begin_line();
        for (k = 0; k < CHARS && !saw_newline; k++) begin
            code  = word[(CHARS-1-k)*stdt_pkg::CODE_BITS +: stdt_pkg::CODE_BITS];
            glyph = CODE_GLYPHS[code];
            ch    = glyph[stdt_pkg::CHAR_BITS-1:0];
            if (ch == stdt_pkg::ASCII_TAB && expand_on) begin
                // pad to the stop; a tab already at/past it pads nothing
                while (cur_col < next_stop)
                    put_char(stdt_pkg::ASCII_SPACE, held, have_held, produced);
                if (stop_idx + 1 < STOPS) begin
                    stop_idx++;
                    next_stop = clamp_col(stop_col[stop_idx]);
                end else begin
                    next_stop = clamp_col(next_stop + stop_step);
                end
            end else begin
                put_char(ch, held, have_held, produced);
                if (ch == stdt_pkg::ASCII_NEWLINE) saw_newline = 1'b1;
            end
        end
        if (saw_newline) begin
            begin_line();
            at_line_start = 1'b1;
        end else begin
            at_line_start = 1'b0;
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_chars.push_back(held);
        end
    endfunction

    // ---------------------------------------------------------------
    // Result check, then prediction for a word taken at the same edge
    // ---------------------------------------------------------------
    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_decoded_char want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual %h col %0d last %0d",
                         $time, out_if.character, out_if.column_after, out_if.last);
                error_count++;
            end else begin
                want = expected_chars.pop_front();
                compare_field("character", 8'(want.character), 8'(out_if.character));
                compare_field("column_after", want.column_after, out_if.column_after);
                compare_field("last", 8'(want.last), 8'(out_if.last));
            end
        end
        if (i_rst_n && in_if.valid && in_if.ready)
            decode_word(in_if.packed_word, in_if.restart);
    end

    // Receiver: random stalls, or a long hold-off when a test asks for one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_asks != hold_seen) begin
            out_if.ready <= 1'b0;
            hold_seen    <= hold_asks;
            hold_left    <= LONG_HOLD;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Driving helpers
    // ---------------------------------------------------------------
    function automatic logic [stdt_pkg::CODE_BITS-1:0] letter_code(input byte c);
        return CODE_A + stdt_pkg::CODE_BITS'(c - "A");
    endfunction

    function automatic logic [WORD_W-1:0] pack_codes(
        input logic [stdt_pkg::CODE_BITS-1:0] c0, c1, c2, c3, c4);
        return {c0, c1, c2, c3, c4};
    endfunction

    // Mostly text with tabs, blanks and some newlines; the rest raw noise.
    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0]              w;
        logic [stdt_pkg::CODE_BITS-1:0] code;
        int                             r;
        int                             k;
        w = '0;
        if ($urandom_range(99) < 30) return WORD_W'($urandom);
        for (k = 0; k < CHARS; k++) begin
            r = $urandom_range(99);
            if (r < 20)      code = CODE_TAB;
            else if (r < 25) code = CODE_NEWLINE;
            else if (r < 40) code = CODE_BLANK;
            else             code = stdt_pkg::CODE_BITS'($urandom_range(63));
            w = {w[WORD_W-stdt_pkg::CODE_BITS-1:0], code};
        end
        return w;
    endfunction

    // valid stays high across back-to-back requests; only a gap lowers it
    task automatic send_word(input logic [WORD_W-1:0] word, input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.packed_word <= word;
        in_if.restart     <= restart;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Idle = nothing outstanding and the input open again, then a quiet settling
    // wait for any word whose characters were all dropped.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0 || !in_if.ready) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [stdt_pkg::CFG_IDX_BITS-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= stdt_pkg::CFG_DATA_BITS'(value);
        @(posedge i_clk);
    endtask

    // Writes all six registers back to back; call only when idle.
    task automatic write_config(input bit expand, input int s1, s2, s3, s4, rep);
        put_reg(stdt_pkg::CFG_EXPAND_TABS, int'(expand));
        put_reg(stdt_pkg::CFG_STOP_FIRST, s1);
        put_reg(stdt_pkg::CFG_STOP_SECOND, s2);
        put_reg(stdt_pkg::CFG_STOP_THIRD, s3);
        put_reg(stdt_pkg::CFG_STOP_FOURTH, s4);
        put_reg(stdt_pkg::CFG_TAB_REPEAT, rep);
        i_cfg_we    <= 1'b0;
        expand_on   = expand;
        stop_col[0] = s1;
        stop_col[1] = s2;
        stop_col[2] = s3;
        stop_col[3] = s4;
        stop_step   = rep;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_plain_text();
        send_word(pack_codes(letter_code("H"), letter_code("E"), letter_code("L"),
                             letter_code("L"), letter_code("O")), 1'b1);
        send_word('0, 1'b0);              // all code zero
        send_word('1, 1'b0);              // all code 63
        // restart in mid line, then carry on without it
        send_word(pack_codes(letter_code("A"), letter_code("B"), letter_code("C"),
                             letter_code("D"), letter_code("E")), 1'b1);
        send_word(pack_codes(CODE_BLANK, CODE_BLANK, letter_code("X"), CODE_BLANK,
                             CODE_BLANK), 1'b0);
    endtask

    // default stops 8/21/31/39, then every 8
    task automatic test_default_tabs();
        send_word(pack_codes(CODE_TAB, letter_code("A"), CODE_TAB, letter_code("B"),
                             CODE_TAB), 1'b1);
        send_word(pack_codes(letter_code("A"), letter_code("B"), letter_code("C"),
                             letter_code("D"), CODE_TAB), 1'b0);
        // column 9 when the tab comes: already past the first stop
        send_word(pack_codes(letter_code("A"), letter_code("A"), letter_code("A"),
                             letter_code("A"), letter_code("A")), 1'b1);
        send_word(pack_codes(letter_code("A"), letter_code("A"), letter_code("A"),
                             CODE_TAB, CODE_TAB), 1'b0);
    endtask

    // newline first, middle and last; the rest of the word is dropped
    task automatic test_newlines();
        send_word(pack_codes(CODE_NEWLINE, letter_code("A"), letter_code("B"),
                             letter_code("C"), letter_code("D")), 1'b0);
        send_word(pack_codes(letter_code("A"), letter_code("B"), CODE_NEWLINE,
                             letter_code("C"), letter_code("D")), 1'b0);
        send_word(pack_codes(letter_code("A"), letter_code("B"), letter_code("C"),
                             letter_code("D"), CODE_NEWLINE), 1'b0);
    endtask

    // Receiver holds off while words keep coming, so the block backs up
    // into its input.
    task automatic test_output_stall();
        int k;
        send_idle_pct = 0;
        hold_asks <= hold_asks + 1;
        for (k = 0; k < 6; k++) send_word(random_word(), k == 0);
        send_idle_pct = 20;
    endtask

    task automatic test_tabs_off();
        wait_idle();
        write_config(1'b0, stdt_pkg::RST_STOP_FIRST, stdt_pkg::RST_STOP_SECOND,
                     stdt_pkg::RST_STOP_THIRD, stdt_pkg::RST_STOP_FOURTH,
                     stdt_pkg::RST_TAB_REPEAT);
        send_word(pack_codes(CODE_TAB, letter_code("A"), CODE_TAB, CODE_NEWLINE,
                             letter_code("B")), 1'b1);
        send_word(pack_codes(CODE_TAB, CODE_TAB, CODE_TAB, CODE_TAB, CODE_TAB), 1'b0);
    endtask

    // every stop at column 1, repeat 1: tabs land on their stop
    task automatic test_tight_stops();
        wait_idle();
        write_config(1'b1, 1, 1, 1, 1, 1);
        send_word(pack_codes(CODE_TAB, CODE_TAB, CODE_TAB, CODE_TAB, CODE_TAB), 1'b1);
        send_word(pack_codes(letter_code("A"), CODE_TAB, letter_code("B"), CODE_TAB,
                             CODE_TAB), 1'b0);
    endtask

    // stops at the top column: result cap, column saturation, empty word
    task automatic test_wide_stops();
        wait_idle();
        write_config(1'b1, 255, 255, 255, 255, 255);
        send_word(pack_codes(CODE_TAB, letter_code("A"), CODE_TAB, letter_code("B"),
                             letter_code("C")), 1'b1);
        send_word(pack_codes(CODE_TAB, CODE_TAB, CODE_TAB, CODE_TAB, CODE_TAB), 1'b0);
        send_word(pack_codes(letter_code("A"), letter_code("B"), letter_code("C"),
                             letter_code("D"), letter_code("E")), 1'b0);
        send_word(pack_codes(letter_code("A"), letter_code("A"), letter_code("A"),
                             letter_code("A"), CODE_TAB), 1'b1);
    endtask

    // Three segments: sender idles 20% / receiver 82%, then swapped,
    // then no idling. Each gets its own register setting.
    task automatic test_random_traffic();
        int seg;
        int k;
        int s1;
        int s2;
        int s3;
        int s4;
        for (seg = 0; seg < 3; seg++) begin
            wait_idle();
            case (seg)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 82;
                    s1 = $urandom_range(1, 10);
                    s2 = s1 + $urandom_range(1, 10);
                    s3 = s2 + $urandom_range(1, 10);
                    s4 = s3 + $urandom_range(1, 10);
                    write_config(1'b1, s1, s2, s3, s4, $urandom_range(1, 8));
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 20;
                    write_config(1'($urandom_range(1)), $urandom_range(1, 255),
                                 $urandom_range(1, 255), $urandom_range(1, 255),
                                 $urandom_range(1, 255), $urandom_range(1, 255));
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    s1 = $urandom_range(1, 16);
                    s2 = s1 + $urandom_range(0, 20);
                    s3 = s2 + $urandom_range(0, 20);
                    s4 = s3 + $urandom_range(0, 20);
                    write_config(1'b1, s1, s2, s3, s4, $urandom_range(1, 16));
                end
            endcase
            for (k = 0; k < SEG_WORDS; k++)
                send_word(random_word(), $urandom_range(99) < 8);
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.packed_word <= '0;
        in_if.restart     <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= stdt_pkg::CFG_EXPAND_TABS;
        i_cfg_data        <= '0;
        // shadow follows the block's reset values
        expand_on     = stdt_pkg::RST_EXPAND_TABS;
        stop_col[0]   = stdt_pkg::RST_STOP_FIRST;
        stop_col[1]   = stdt_pkg::RST_STOP_SECOND;
        stop_col[2]   = stdt_pkg::RST_STOP_THIRD;
        stop_col[3]   = stdt_pkg::RST_STOP_FOURTH;
        stop_step     = stdt_pkg::RST_TAB_REPEAT;
        cur_col       = 1;
        stop_idx      = 0;
        next_stop     = stdt_pkg::RST_STOP_FIRST;
        at_line_start = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_text();
        test_default_tabs();
        test_newlines();
        test_output_stall();
        test_tabs_off();
        test_tight_stops();
        test_wide_stops();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
